FILE: src/bwht_pkg.sv
`timescale 1ns / 1ps
package bwht_pkg;

  localparam int MAP_AW   = 16;   // 65536 block maps
  localparam int CHUNK_AW = 8;    // 256 chunk counters
  localparam int SWEEP_W  = MAP_AW + 1;
  localparam int DIV_W    = 33;

  localparam logic [31:0] WPW_RESET  = 32'd4096;
  localparam logic [31:0] WPD_RESET  = 32'd65536;
  localparam logic [16:0] BIU_RESET  = 17'd65536;

  typedef enum logic [1:0] {
    REG_BLOCKS_IN_USE     = 2'd0,
    REG_WRITES_PER_WINDOW = 2'd1,
    REG_WRITES_PER_DECAY  = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_CLR_MAP,
    S_CLR_CHUNK,
    S_IDLE,
    S_START,
    S_DIV,
    S_WCLR,
    S_RD,
    S_WR,
    S_DECAY,
    S_QOUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic win_step;
    logic div_start;
    logic win_apply;
    logic sweep_en;
    logic sweep_chunk;
    logic sweep_zero;
    logic mem_wr;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_range;
    logic p_below_len;
    logic div_done;
    logic sweep_done;
    logic decay_due;
  } dp_status_t;

endpackage

FILE: src/block_write_hotness_tracker_top.sv
`timescale 1ns / 1ps
// channel   ports                                            direction
// request   start, busy, command, block_address              in (start & !busy)
// result    result_valid, recency_score, window_hits,
//           chunk_writes                                     out, one-cycle strobe
// config    cfg_we, cfg_index, cfg_data                      in, no wait
//
// A query passes S_START and S_QOUT and its result is strobed from a register. A write
// passes S_START and S_WR (an out-of-range write ends after S_START) when the window
// does not roll over. A window rollover adds a division plus a sweep of the block-map
// memory (one entry a cycle) and, for an in-range write, a re-read of the entry.
// A decay adds a sweep of the chunk counters.
// After reset busy stays high while both stores are cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module block_write_hotness_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] block_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [7:0]  recency_score,
  output logic [3:0]  window_hits,
  output logic [31:0] chunk_writes
);
  import bwht_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  bwht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  bwht_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .block_address (block_address),
    .result_valid  (result_valid),
    .recency_score (recency_score),
    .window_hits   (window_hits),
    .chunk_writes  (chunk_writes)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_empty_map_score: assert property (@(posedge clk) disable iff (rst)
    (result_valid && window_hits == 4'd0) |-> (recency_score == 8'd0))
    else $error("non-zero score with no window hits");

  a_result_needs_query: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy == 1'b0)
    else $error("result while still busy");

endmodule

FILE: src/bwht_ctrl.sv
`timescale 1ns / 1ps
module bwht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bwht_pkg::dp_status_t st,
  output bwht_pkg::ctrl_cmd_t  cmd
);
  import bwht_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR_MAP;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR_MAP:   if (st.sweep_done) state_next = S_CLR_CHUNK;
      S_CLR_CHUNK: if (st.sweep_done) state_next = S_IDLE;
      S_IDLE:      if (start) state_next = S_START;
      S_START: begin
        if (st.is_query)          state_next = S_QOUT;
        else if (!st.p_below_len) state_next = S_DIV;
        else if (st.in_range)     state_next = S_WR;
        else                      state_next = S_IDLE;
      end
      S_DIV:   if (st.div_done) state_next = S_WCLR;
      S_WCLR:  if (st.sweep_done) state_next = st.in_range ? S_RD : S_IDLE;
      S_RD:    state_next = S_WR;
      S_WR:    state_next = st.decay_due ? S_DECAY : S_IDLE;
      S_DECAY: if (st.sweep_done) state_next = S_IDLE;
      S_QOUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_CLR_MAP: begin
        cmd.sweep_en   = 1'b1;
        cmd.sweep_zero = 1'b1;
      end
      S_CLR_CHUNK: begin
        cmd.sweep_en    = 1'b1;
        cmd.sweep_chunk = 1'b1;
        cmd.sweep_zero  = 1'b1;
      end
      S_IDLE: begin
        busy         = 1'b0;
        cmd.latch_in = start;
      end
      S_START: begin
        cmd.win_step  = !st.is_query && st.p_below_len;
        cmd.div_start = !st.is_query && !st.p_below_len;
      end
      S_DIV:   cmd.win_apply = st.div_done;
      S_WCLR:  cmd.sweep_en = 1'b1;
      S_RD:    ;
      S_WR:    cmd.mem_wr = 1'b1;
      S_DECAY: begin
        cmd.sweep_en    = 1'b1;
        cmd.sweep_chunk = 1'b1;
      end
      S_QOUT:  cmd.result_load = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: src/bwht_dp.sv
`timescale 1ns / 1ps
module bwht_dp (
  input  logic                clk,
  input  logic                rst,
  input  bwht_pkg::ctrl_cmd_t cmd,
  output bwht_pkg::dp_status_t st,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                command,
  input  logic [31:0]         block_address,
  output logic                result_valid,
  output logic [7:0]          recency_score,
  output logic [3:0]          window_hits,
  output logic [31:0]         chunk_writes
);
  import bwht_pkg::*;

  logic [16:0] blocks_in_use;
  logic [31:0] writes_per_window;
  logic [31:0] writes_per_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use     <= BIU_RESET;
      writes_per_window <= WPW_RESET;
      writes_per_decay  <= WPD_RESET;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_BLOCKS_IN_USE:     blocks_in_use     <= cfg_data[16:0];
        REG_WRITES_PER_WINDOW: writes_per_window <= cfg_data;
        REG_WRITES_PER_DECAY:  writes_per_decay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic        is_query;
  logic [31:0] addr;
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      is_query <= command;
      addr     <= block_address;
    end
  end

  logic in_range;
  assign in_range = (addr[31:MAP_AW] == '0) && ({1'b0, addr[MAP_AW-1:0]} < blocks_in_use);

  // window state
  logic [2:0]  widx;
  logic [31:0] wprog;
  logic [31:0] dprog;
  logic [7:0]  keep_mask;

  logic [DIV_W-1:0] p, wlen;
  assign p    = {1'b0, wprog} + 33'd1;
  assign wlen = (writes_per_window == '0) ? 33'd1 : {1'b0, writes_per_window};

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0] div_q, div_r, r_sh;
  logic [5:0]       div_cnt;
  logic             r_ge;
  assign r_sh = {div_r[DIV_W-2:0], div_q[DIV_W-1]};
  assign r_ge = r_sh >= wlen;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= 6'(DIV_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q <= p;
      div_r <= '0;
    end else if (div_cnt != '0) begin
      div_r <= r_ge ? r_sh - wlen : r_sh;
      div_q <= {div_q[DIV_W-2:0], r_ge};
    end
  end

  logic [2:0] newidx;
  logic [7:0] clr_bits;
  assign newidx = widx + div_q[2:0];

  always_comb begin
    logic [2:0] pos;
    clr_bits = '0;
    for (int j = 0; j < 8; j++) begin
      pos = newidx - 3'(j);
      if ((div_q[DIV_W-1:3] != '0) || (3'(j) < div_q[2:0])) clr_bits[pos] = 1'b1;
    end
  end

  logic [31:0] dp1;
  logic        decay_due;
  assign dp1       = dprog + 32'd1;
  assign decay_due = !(dp1 < writes_per_decay);

  always_ff @(posedge clk) begin
    if (rst) begin
      widx      <= '0;
      wprog     <= '0;
      dprog     <= '0;
      keep_mask <= '1;
    end else begin
      if (cmd.win_step) wprog <= p[31:0];
      if (cmd.win_apply) begin
        wprog     <= div_r[31:0];
        widx      <= newidx;
        keep_mask <= ~clr_bits;
      end
      if (cmd.mem_wr) dprog <= decay_due ? dp1 - writes_per_decay : dp1;
    end
  end

  // store sweeps: read one entry a cycle, write it back in the cycle after
  logic [SWEEP_W-1:0] sw;
  logic               pw_valid;
  logic [MAP_AW-1:0]  pw_addr;
  logic               sw_end, sweep_done;
  assign sw_end     = cmd.sweep_chunk ? sw[CHUNK_AW] : sw[MAP_AW];
  assign sweep_done = cmd.sweep_en && sw_end && !pw_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw       <= '0;
      pw_valid <= 1'b0;
    end else begin
      pw_valid <= cmd.sweep_en && !sw_end;
      if (!cmd.sweep_en || sweep_done) sw <= '0;
      else if (!sw_end)                sw <= sw + 1'b1;
    end
  end
  always_ff @(posedge clk) pw_addr <= sw[MAP_AW-1:0];

  // memories
  logic [7:0]  map_mem [2**MAP_AW];
  logic [31:0] chunk_mem [2**CHUNK_AW];
  logic [7:0]  map_rd;
  logic [31:0] chunk_rd;
  logic [MAP_AW-1:0]   map_ra;
  logic [CHUNK_AW-1:0] chunk_ra;

  assign map_ra   = cmd.sweep_en ? sw[MAP_AW-1:0] : addr[MAP_AW-1:0];
  assign chunk_ra = cmd.sweep_en ? sw[CHUNK_AW-1:0] : addr[MAP_AW-1:MAP_AW-CHUNK_AW];

  logic                map_we, chunk_we;
  logic [MAP_AW-1:0]   map_wa;
  logic [CHUNK_AW-1:0] chunk_wa;
  logic [7:0]          map_wd;
  logic [31:0]         chunk_wd;

  always_comb begin
    map_we   = 1'b0;
    chunk_we = 1'b0;
    map_wa   = addr[MAP_AW-1:0];
    chunk_wa = addr[MAP_AW-1:MAP_AW-CHUNK_AW];
    map_wd   = map_rd | (8'd1 << widx);
    chunk_wd = (chunk_rd == '1) ? chunk_rd : chunk_rd + 32'd1;
    if (cmd.mem_wr) begin
      map_we   = 1'b1;
      chunk_we = 1'b1;
    end else if (pw_valid) begin
      map_wa   = pw_addr;
      chunk_wa = pw_addr[CHUNK_AW-1:0];
      map_wd   = cmd.sweep_zero ? 8'd0 : (map_rd & keep_mask);
      chunk_wd = cmd.sweep_zero ? 32'd0 : (chunk_rd >> 1);
      map_we   = !cmd.sweep_chunk;
      chunk_we = cmd.sweep_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (chunk_we) chunk_mem[chunk_wa] <= chunk_wd;
    chunk_rd <= chunk_mem[chunk_ra];
  end

  // query result
  logic [7:0] score;
  logic [3:0] hits;
  always_comb begin
    logic [2:0] back;
    score = '0;
    hits  = '0;
    for (int i = 0; i < 8; i++) begin
      back = widx - 3'(i);
      if (map_rd[i]) begin
        score = score + (8'd128 >> back);
        hits  = hits + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= cmd.result_load;
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      recency_score <= in_range ? score : 8'd0;
      window_hits   <= in_range ? hits : 4'd0;
      chunk_writes  <= in_range ? chunk_rd : 32'd0;
    end
  end

  assign st.is_query    = is_query;
  assign st.in_range    = in_range;
  assign st.p_below_len = p < wlen;
  assign st.div_done    = (div_cnt == '0);
  assign st.sweep_done  = sweep_done;
  assign st.decay_due   = decay_due;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import bwht_pkg::*;

  typedef struct packed {
    logic [7:0]  score;
    logic [3:0]  hits;
    logic [31:0] count;
  } feature_t;

  class hotness_scoreboard;
    logic [7:0]  block_map [65536];
    logic [31:0] chunk_count [256];
    logic [2:0]  win_idx;
    logic [31:0] win_prog;
    logic [31:0] decay_prog;
    logic [16:0] biu;
    logic [31:0] wpw;
    logic [31:0] wpd;
    feature_t    pending_features [$];
    int          errors;
    int          queries_seen;

    function new();
      foreach (block_map[i]) block_map[i] = '0;
      foreach (chunk_count[i]) chunk_count[i] = '0;
      win_idx = '0;
      win_prog = '0;
      decay_prog = '0;
      biu = BIU_RESET;
      wpw = WPW_RESET;
      wpd = WPD_RESET;
      errors = 0;
      queries_seen = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] data);
      case (idx)
        REG_BLOCKS_IN_USE:     biu = data[16:0];
        REG_WRITES_PER_WINDOW: wpw = data;
        REG_WRITES_PER_DECAY:  wpd = data;
        default: ;
      endcase
    endfunction

    function bit addr_ok(logic [31:0] addr);
      longint lim;
      lim = (biu > 17'd65536) ? 65536 : longint'(biu);
      return longint'(addr) < lim;
    endfunction

    function void roll_window();
      longint unsigned len, p, steps;
      logic [2:0] nidx;
      logic [7:0] keep;
      int n;
      len = (wpw == 0) ? 1 : longint'(wpw);
      p = longint'(win_prog) + 1;
      if (p < len) begin
        win_prog = p[31:0];
        return;
      end
      steps = p / len;
      win_prog = 32'(p % len);
      nidx = win_idx + 3'(steps & 7);
      n = (steps < 8) ? int'(steps) : 8;
      keep = 8'hFF;
      for (int j = 0; j < n; j++) keep[3'(nidx - 3'(j))] = 1'b0;
      foreach (block_map[i]) block_map[i] &= keep;
      win_idx = nidx;
    endfunction

    function void note_request(logic cmd, logic [31:0] addr);
      feature_t f;
      logic [7:0] bits;
      int sc;
      if (cmd == 1'b0) begin
        roll_window();
        if (!addr_ok(addr)) return;
        block_map[addr[15:0]][win_idx] = 1'b1;
        if (chunk_count[addr[15:8]] != 32'hFFFFFFFF)
          chunk_count[addr[15:8]]++;
        decay_prog = decay_prog + 1;
        if (decay_prog >= wpd) begin
          decay_prog = decay_prog - wpd;
          foreach (chunk_count[i]) chunk_count[i] >>= 1;
        end
        return;
      end
      f = '0;
      if (addr_ok(addr)) begin
        bits = block_map[addr[15:0]];
        sc = 0;
        for (int i = 0; i < 8; i++) begin
          if (bits[i]) begin
            sc += 128 >> int'(3'(win_idx - 3'(i)));
            f.hits++;
          end
        end
        f.score = (sc > 255) ? 8'd255 : 8'(sc);
        f.count = chunk_count[addr[15:8]];
      end
      pending_features.push_back(f);
    endfunction

    function void check_result(logic [7:0] sc, logic [3:0] hi, logic [31:0] cw);
      feature_t e;
      queries_seen++;
      if (pending_features.size() == 0) begin
        $display("%0t: unexpected result score=%0d hits=%0d count=%0d", $time, sc, hi, cw);
        errors++;
        return;
      end
      e = pending_features.pop_front();
      if (sc !== e.score) begin
        $display("%0t: recency_score expected %0d actual %0d", $time, e.score, sc);
        errors++;
      end
      if (hi !== e.hits) begin
        $display("%0t: window_hits expected %0d actual %0d", $time, e.hits, hi);
        errors++;
      end
      if (cw !== e.count) begin
        $display("%0t: chunk_writes expected %0d actual %0d", $time, e.count, cw);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = 1'b0;
  logic [31:0] block_address = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [7:0]  recency_score;
  logic [3:0]  window_hits;
  logic [31:0] chunk_writes;

  hotness_scoreboard sb = new();
  int requests_sent = 0;
  int burst_left = 0;

  always #1 clk = ~clk;

  block_write_hotness_tracker_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .block_address(block_address), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .result_valid(result_valid), .recency_score(recency_score),
    .window_hits(window_hits), .chunk_writes(chunk_writes)
  );

  always @(posedge clk)
    if (!rst && result_valid) sb.check_result(recency_score, window_hits, chunk_writes);

  // one request; start stays high through a burst, a nonzero gap drops it between bursts
  task automatic send_request(logic cmd, logic [31:0] addr);
    int gap;
    @(negedge clk);
    start = 1'b1;
    command = cmd;
    block_address = addr;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(cmd, addr);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < gap; i++) begin
        @(negedge clk);
        start = 1'b0;
        command = $urandom_range(0, 1);
        block_address = $urandom;
      end
    end
  endtask

  // block idle: queries answered and any sweep finished
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_features.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_requests(int count, int query_pct);
    logic [31:0] addr;
    int r, lim;
    for (int k = 0; k < count; k++) begin
      lim = (sb.biu > 17'd65536) ? 65536 : int'(sb.biu);
      r = $urandom_range(0, 99);
      if (r < 70 && lim > 0) addr = $urandom_range(0, lim - 1);
      else if (r < 85) addr = 32'(lim) + $urandom_range(0, 3) - 2;
      else addr = $urandom;
      send_request($urandom_range(0, 99) < query_pct, addr);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: address extremes and boundary under reset settings
    send_request(1'b1, 32'd0);
    send_request(1'b1, 32'hFFFFFFFF);
    send_request(1'b0, 32'd0);
    send_request(1'b0, 32'd65535);
    send_request(1'b0, 32'd65536);
    send_request(1'b0, 32'hFFFFFFFF);
    send_request(1'b0, 32'd255);
    send_request(1'b0, 32'd256);
    send_request(1'b1, 32'd0);
    send_request(1'b1, 32'd255);
    send_request(1'b1, 32'd256);
    send_request(1'b1, 32'd65535);
    send_request(1'b1, 32'd65536);
    send_request(1'b1, 32'h80000000);
    settle();

    // small device, frequent decay, no rollover
    write_reg(REG_BLOCKS_IN_USE, 32'd300);
    write_reg(REG_WRITES_PER_WINDOW, 32'hFFFFFFFF);
    write_reg(REG_WRITES_PER_DECAY, 32'd7);
    random_requests(600, 50);
    settle();

    // short windows: several rollovers, hot set kept tiny
    write_reg(REG_BLOCKS_IN_USE, 32'd64);
    write_reg(REG_WRITES_PER_WINDOW, 32'd50);
    random_requests(400, 50);
    settle();

    // window length lowered below progress, then zero length
    write_reg(REG_WRITES_PER_WINDOW, 32'd1000);
    random_requests(30, 0);
    random_requests(10, 100);
    settle();
    write_reg(REG_WRITES_PER_WINDOW, 32'd3);
    send_request(1'b0, 32'd5);
    random_requests(8, 100);
    settle();
    write_reg(REG_WRITES_PER_WINDOW, 32'd0);
    send_request(1'b0, 32'd5);
    send_request(1'b0, 32'd6);
    send_request(1'b1, 32'd5);
    send_request(1'b1, 32'd6);
    settle();

    // empty device, then oversized register with decay on every write
    write_reg(REG_WRITES_PER_WINDOW, 32'hFFFFFFFF);
    write_reg(REG_BLOCKS_IN_USE, 32'd0);
    random_requests(40, 50);
    settle();
    write_reg(REG_BLOCKS_IN_USE, 32'h1FFFF);
    write_reg(REG_WRITES_PER_DECAY, 32'd0);
    random_requests(100, 50);
    settle();

    // full device set, then 1024 blocks; long decay then decay length lowered
    write_reg(REG_BLOCKS_IN_USE, 32'd65536);
    write_reg(REG_WRITES_PER_DECAY, 32'hFFFFFFFF);
    write_reg(REG_BLOCKS_IN_USE, 32'd1024);
    random_requests(200, 40);
    settle();
    write_reg(REG_WRITES_PER_DECAY, 32'd1);
    random_requests(150, 50);
    settle();
    write_reg(REG_WRITES_PER_DECAY, 32'd40);
    random_requests(400, 45);
    settle();
    repeat (20) @(negedge clk);

    if (sb.pending_features.size() != 0) begin
      $display("%0t: %0d query results never arrived", $time, sb.pending_features.size());
      sb.errors++;
    end
    $display("Ran %0d requests, checked %0d query results over several register settings,",
             requests_sent, sb.queries_seen);
    $display("including window rollovers, decays and out-of-range addresses.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout at %0t", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
